// File: sv/ectc_pkg.sv
// ----------------------------------------------------------------------------
// ectc_pkg
// Shared widths, span limits, reciprocal constants and stage payload types
// for the epoch to civil time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ectc_pkg;

  localparam int EPOCH_W = 35;
  localparam int U_W     = 34;
  localparam int LOW_W   = 7;
  localparam int Q7_W    = U_W - LOW_W;
  localparam int DAY_W   = 18;
  localparam int SOD_W   = 17;
  localparam int R675_W  = SOD_W - LOW_W;

  localparam int SPLIT_STAGES = 3;
  localparam int DATE_STAGES  = 6;
  localparam int PIPE_DEPTH   = SPLIT_STAGES + DATE_STAGES;

  localparam logic signed [EPOCH_W-1:0] SPAN_LOW  = -35'sd2208988800;
  localparam logic signed [EPOCH_W-1:0] SPAN_HIGH = 35'sd13569465599;
  localparam logic [EPOCH_W-1:0]        SHIFT_1900 = 35'd2208988800;

  // seconds per day is 128 * 675
  localparam int          K675   = 37;
  localparam logic [63:0] M675_W = ((64'd1 << K675) + 64'd674) / 64'd675;
  localparam logic [27:0] M675   = M675_W[27:0];
  localparam logic [9:0]  D675   = 10'd675;

  // days from 0000-03-01 to 1900-01-01, and era starts in that count
  localparam logic [19:0] Z_OFS       = 20'd693901;
  localparam logic [19:0] ERA4_START  = 20'd584388;
  localparam logic [19:0] ERA5_START  = 20'd730485;
  localparam logic [11:0] ERA4_YEAR   = 12'd1600;
  localparam logic [11:0] ERA5_YEAR   = 12'd2000;

  localparam logic [DAY_W-1:0] CENT1 = 18'd36524;
  localparam logic [DAY_W-1:0] CENT2 = 18'd73048;
  localparam logic [DAY_W-1:0] CENT3 = 18'd109572;
  localparam logic [DAY_W-1:0] CENT4 = 18'd146096;

  localparam int          K1460   = 29;
  localparam logic [63:0] M1460_W = ((64'd1 << K1460) + 64'd1459) / 64'd1460;
  localparam logic [18:0] M1460   = M1460_W[18:0];

  localparam int          K365   = 27;
  localparam logic [63:0] M365_W = ((64'd1 << K365) + 64'd364) / 64'd365;
  localparam logic [18:0] M365   = M365_W[18:0];

  localparam int          K153   = 20;
  localparam logic [63:0] M153_W = ((64'd1 << K153) + 64'd152) / 64'd153;
  localparam logic [12:0] M153   = M153_W[12:0];

  localparam int          K3600   = 29;
  localparam logic [63:0] M3600_W = ((64'd1 << K3600) + 64'd3599) / 64'd3600;
  localparam logic [17:0] M3600   = M3600_W[17:0];

  localparam int          K60   = 18;
  localparam logic [63:0] M60_W = ((64'd1 << K60) + 64'd59) / 64'd60;
  localparam logic [12:0] M60   = M60_W[12:0];

  typedef struct packed {
    logic [DAY_W-1:0] days;
    logic [SOD_W-1:0] sod;
  } day_sod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

endpackage

`default_nettype wire

// File: sv/ectc_split.sv
// ----------------------------------------------------------------------------
// ectc_split
// Three stages: rebase to 1900-01-01, then divide by 86400 into a day count
// and a second of the day.
// ----------------------------------------------------------------------------
`default_nettype none

module ectc_split (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [ectc_pkg::EPOCH_W-1:0]  epoch,
  output ectc_pkg::day_sod_t                        split
);

  logic [ectc_pkg::EPOCH_W-1:0] sum_nxt;
  logic [ectc_pkg::U_W-1:0]     u_r;

  logic [ectc_pkg::Q7_W-1:0]    q7_nxt;
  logic [54:0]                  prod_nxt;
  logic [ectc_pkg::DAY_W-1:0]   q_r;
  logic [ectc_pkg::Q7_W-1:0]    q7_r;
  logic [ectc_pkg::LOW_W-1:0]   low_r;

  logic [27:0]                  qm_nxt;
  logic [ectc_pkg::Q7_W-1:0]    r_nxt;
  ectc_pkg::day_sod_t           split_r;

  assign sum_nxt  = epoch + ectc_pkg::SHIFT_1900;
  assign q7_nxt   = u_r[ectc_pkg::U_W-1:ectc_pkg::LOW_W];
  assign prod_nxt = 55'(q7_nxt) * 55'(ectc_pkg::M675);
  assign qm_nxt   = 28'(q_r) * 28'(ectc_pkg::D675);
  assign r_nxt    = q7_r - qm_nxt[ectc_pkg::Q7_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      u_r          <= sum_nxt[ectc_pkg::U_W-1:0];
      q_r          <= prod_nxt[ectc_pkg::K675 +: ectc_pkg::DAY_W];
      q7_r         <= q7_nxt;
      low_r        <= u_r[ectc_pkg::LOW_W-1:0];
      split_r.days <= q_r;
      split_r.sod  <= {r_nxt[ectc_pkg::R675_W-1:0], low_r};
    end
  end

  assign split = split_r;

endmodule

`default_nettype wire

// File: sv/ectc_clock.sv
// ----------------------------------------------------------------------------
// ectc_clock
// Six stages: second of the day into hour, minute and second, padded to
// line up with the date path.
// ----------------------------------------------------------------------------
`default_nettype none

module ectc_clock (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ectc_pkg::SOD_W-1:0]  sod,
  output ectc_pkg::tod_t                   tod
);

  logic [34:0]                 hprod_nxt;
  logic [4:0]                  hour3_r;
  logic [ectc_pkg::SOD_W-1:0]  sod3_r;

  logic [ectc_pkg::SOD_W-1:0]  hsec_nxt;
  logic [ectc_pkg::SOD_W-1:0]  r1_nxt;
  logic [11:0]                 r1_r;
  logic [4:0]                  hour4_r;

  logic [24:0]                 mprod_nxt;
  logic [11:0]                 r1_5_r;
  logic [4:0]                  hour5_r;
  logic [5:0]                  min5_r;

  logic [11:0]                 msec_nxt;
  logic [11:0]                 sec_nxt;
  ectc_pkg::tod_t              tod6_r;
  ectc_pkg::tod_t              tod7_r;
  ectc_pkg::tod_t              tod8_r;

  assign hprod_nxt = 35'(sod) * 35'(ectc_pkg::M3600);
  assign hsec_nxt  = 17'(hour3_r) * 17'd3600;
  assign r1_nxt    = sod3_r - hsec_nxt;
  assign mprod_nxt = 25'(r1_r) * 25'(ectc_pkg::M60);
  assign msec_nxt  = 12'(min5_r) * 12'd60;
  assign sec_nxt   = r1_5_r - msec_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      hour3_r        <= hprod_nxt[ectc_pkg::K3600 +: 5];
      sod3_r         <= sod;
      r1_r           <= r1_nxt[11:0];
      hour4_r        <= hour3_r;
      r1_5_r         <= r1_r;
      hour5_r        <= hour4_r;
      min5_r         <= mprod_nxt[ectc_pkg::K60 +: 6];
      tod6_r.hour    <= hour5_r;
      tod6_r.minute  <= min5_r;
      tod6_r.second  <= sec_nxt[5:0];
      tod7_r         <= tod6_r;
      tod8_r         <= tod7_r;
    end
  end

  assign tod = tod8_r;

endmodule

`default_nettype wire

// File: sv/ectc_date.sv
// ----------------------------------------------------------------------------
// ectc_date
// Six stages: day count since 1900-01-01 into year, month, day and weekday
// by the era / year-of-era method.
// ----------------------------------------------------------------------------
`default_nettype none

module ectc_date (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ectc_pkg::DAY_W-1:0]  days,
  output ectc_pkg::date_t                  date
);

  function automatic logic [2:0] mod7(input logic [18:0] v);
    logic [20:0] p;
    logic [5:0]  s1;
    logic [3:0]  s2;
    p  = {2'b00, v};
    s1 = '0;
    for (int i = 0; i < 7; i++) begin
      s1 = s1 + 6'(p[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // first day of each month, march-based
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // stage 3
  logic [19:0]                 z_nxt;
  logic                        era5_nxt;
  logic [19:0]                 doe_nxt;
  logic [ectc_pkg::DAY_W-1:0]  doe3_r;
  logic                        era5_3_r;
  logic [2:0]                  wd3_r;

  // stage 4
  logic [36:0]                 p1460_nxt;
  logic [2:0]                  cent_nxt;
  logic [18:0]                 t_nxt;
  logic [ectc_pkg::DAY_W-1:0]  doe4_r;
  logic                        era5_4_r;
  logic [2:0]                  wd4_r;
  logic [ectc_pkg::DAY_W-1:0]  t_r;

  // stage 5
  logic [36:0]                 p365_nxt;
  logic [ectc_pkg::DAY_W-1:0]  doe5_r;
  logic                        era5_5_r;
  logic [2:0]                  wd5_r;
  logic [8:0]                  yoe_r;

  // stage 6
  logic [1:0]                  c100_nxt;
  logic [ectc_pkg::DAY_W-1:0]  yd_nxt;
  logic [ectc_pkg::DAY_W-1:0]  doy_nxt;
  logic [8:0]                  doy6_r;
  logic [11:0]                 yy6_r;
  logic [2:0]                  wd6_r;

  // stage 7
  logic [11:0]                 v_nxt;
  logic [24:0]                 p153_nxt;
  logic [8:0]                  doy7_r;
  logic [11:0]                 yy7_r;
  logic [2:0]                  wd7_r;
  logic [3:0]                  mp7_r;

  // stage 8
  logic [8:0]                  dd_nxt;
  logic [3:0]                  mm_nxt;
  ectc_pkg::date_t             date_r;

  assign z_nxt    = 20'(days) + ectc_pkg::Z_OFS;
  assign era5_nxt = (z_nxt >= ectc_pkg::ERA5_START);
  assign doe_nxt  = z_nxt - (era5_nxt ? ectc_pkg::ERA5_START : ectc_pkg::ERA4_START);

  assign p1460_nxt = 37'(doe3_r) * 37'(ectc_pkg::M1460);
  always_comb begin
    if (doe3_r >= ectc_pkg::CENT4) begin
      cent_nxt = 3'd4;
    end else if (doe3_r >= ectc_pkg::CENT3) begin
      cent_nxt = 3'd3;
    end else if (doe3_r >= ectc_pkg::CENT2) begin
      cent_nxt = 3'd2;
    end else if (doe3_r >= ectc_pkg::CENT1) begin
      cent_nxt = 3'd1;
    end else begin
      cent_nxt = 3'd0;
    end
  end
  assign t_nxt = 19'(doe3_r) - 19'(p1460_nxt[ectc_pkg::K1460 +: 8]) + 19'(cent_nxt)
                 - 19'(doe3_r == ectc_pkg::CENT4);

  assign p365_nxt = 37'(t_r) * 37'(ectc_pkg::M365);

  always_comb begin
    if (yoe_r >= 9'd300) begin
      c100_nxt = 2'd3;
    end else if (yoe_r >= 9'd200) begin
      c100_nxt = 2'd2;
    end else if (yoe_r >= 9'd100) begin
      c100_nxt = 2'd1;
    end else begin
      c100_nxt = 2'd0;
    end
  end
  assign yd_nxt  = 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(c100_nxt);
  assign doy_nxt = doe5_r - yd_nxt;

  assign v_nxt    = 12'(doy6_r) * 12'd5 + 12'd2;
  assign p153_nxt = 25'(v_nxt) * 25'(ectc_pkg::M153);

  assign dd_nxt = doy7_r - month_start(mp7_r) + 9'd1;
  assign mm_nxt = (mp7_r < 4'd10) ? (mp7_r + 4'd3) : (mp7_r - 4'd9);

  always_ff @(posedge clk) begin
    if (en) begin
      doe3_r   <= doe_nxt[ectc_pkg::DAY_W-1:0];
      era5_3_r <= era5_nxt;
      wd3_r    <= mod7(19'(days) + 19'd1);

      doe4_r   <= doe3_r;
      era5_4_r <= era5_3_r;
      wd4_r    <= wd3_r;
      t_r      <= t_nxt[ectc_pkg::DAY_W-1:0];

      doe5_r   <= doe4_r;
      era5_5_r <= era5_4_r;
      wd5_r    <= wd4_r;
      yoe_r    <= p365_nxt[ectc_pkg::K365 +: 9];

      doy6_r   <= doy_nxt[8:0];
      yy6_r    <= (era5_5_r ? ectc_pkg::ERA5_YEAR : ectc_pkg::ERA4_YEAR) + 12'(yoe_r);
      wd6_r    <= wd5_r;

      doy7_r   <= doy6_r;
      yy7_r    <= yy6_r;
      wd7_r    <= wd6_r;
      mp7_r    <= p153_nxt[ectc_pkg::K153 +: 4];

      date_r.year         <= yy7_r + 12'(mm_nxt <= 4'd2);
      date_r.month        <= mm_nxt;
      date_r.day_of_month <= dd_nxt[4:0];
      date_r.weekday      <= wd7_r;
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

// File: sv/epoch_to_civil_time.sv
// ----------------------------------------------------------------------------
// epoch_to_civil_time
// Signed Unix seconds to proleptic Gregorian UTC date, time and weekday.
//
// in_ channel: one 35-bit signed timestamp per beat. out_ channel: one beat
// per input beat, in order, with year, month, day, hour, minute, second,
// weekday (sunday 0) and a range flag. Timestamps before 1900-01-01 or after
// 2399-12-31 23:59:59 give range_error 1 and all other fields zero.
// Nine register stages (3 for the day split, 6 for the calendar) lie between
// an accepted beat and its result beat. One beat enters per cycle while
// in_stall is low, so sustained throughput is one beat per clock while
// out_stall stays low.
// The whole pipeline advances together; it holds only while the output
// register is full and out_stall is high, and in_stall is raised in exactly
// those cycles, so a beat is never lost or repeated and bubbles drain out.
// Synchronous reset empties the pipeline; no state survives across beats.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_civil_time (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [ectc_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [11:0]                               out_year,
  output logic [3:0]                                out_month,
  output logic [4:0]                                out_day_of_month,
  output logic [4:0]                                out_hour,
  output logic [5:0]                                out_minute,
  output logic [5:0]                                out_second,
  output logic [2:0]                                out_weekday,
  output logic                                      out_range_error
);

  logic                               en;
  logic                               err_nxt;
  logic [ectc_pkg::PIPE_DEPTH-1:0]    vld_r;
  logic [ectc_pkg::PIPE_DEPTH-1:0]    err_r;
  ectc_pkg::day_sod_t                 split;
  ectc_pkg::date_t                    date;
  ectc_pkg::tod_t                     tod;
  logic                               err;

  assign en       = !(vld_r[ectc_pkg::PIPE_DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign err_nxt  = (in_epoch_seconds < ectc_pkg::SPAN_LOW) ||
                    (in_epoch_seconds > ectc_pkg::SPAN_HIGH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ectc_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= {err_r[ectc_pkg::PIPE_DEPTH-2:0], err_nxt};
    end
  end

  ectc_split u_split (
    .clk   (clk),
    .en    (en),
    .epoch (in_epoch_seconds),
    .split (split)
  );

  ectc_date u_date (
    .clk  (clk),
    .en   (en),
    .days (split.days),
    .date (date)
  );

  ectc_clock u_clock (
    .clk (clk),
    .en  (en),
    .sod (split.sod),
    .tod (tod)
  );

  assign err              = err_r[ectc_pkg::PIPE_DEPTH-1];
  assign out_valid        = vld_r[ectc_pkg::PIPE_DEPTH-1];
  assign out_range_error  = err;
  assign out_year         = err ? '0 : date.year;
  assign out_month        = err ? '0 : date.month;
  assign out_day_of_month = err ? '0 : date.day_of_month;
  assign out_weekday      = err ? '0 : date.weekday;
  assign out_hour         = err ? '0 : tod.hour;
  assign out_minute       = err ? '0 : tod.minute;
  assign out_second       = err ? '0 : tod.second;

  // in-span beats carry a real calendar date
  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |->
      out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month != 5'd0 &&
      out_year >= 12'd1900 && out_year <= 12'd2399)
    else $error("calendar fields out of range on an in-span beat");

  a_time_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |->
      out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60 &&
      out_weekday < 3'd7)
    else $error("time of day or weekday out of range on an in-span beat");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held off while the output register can move");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

endmodule

`default_nettype wire

// File: tb/tb_epoch_to_civil_time.sv
// ----------------------------------------------------------------------------
// tb_epoch_to_civil_time
// Self-checking bench for the Unix seconds to civil date converter. A queue
// of timestamps feeds a clocked driver; a clocked monitor compares every
// result beat with the date computed here from the accepted timestamp.
// Covers span edges, leap and century days, negative stamps, out-of-span
// patterns and random dates, with random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epoch_to_civil_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW         = ectc_pkg::EPOCH_W;
  localparam int QUIET_MAX  = 2000;
  localparam int HOLD_LEN   = 80;
  localparam int HOLD_AT    = 300;
  localparam int STEADY_LO  = 900;
  localparam int STEADY_HI  = 1300;
  localparam int GAP_PCT    = 31;
  localparam int N_RANDOM   = 1950;
  localparam int DRAIN      = 30;
  localparam int SHOW_MAX   = 10;

  localparam longint SECS_DAY   = 86400;
  localparam longint DAYS_ERA   = 146097;
  localparam longint DAYS_SHIFT = 719468;

  typedef logic signed [EW-1:0] stamp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        range_error;
  } civil_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  stamp_t      in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic        out_range_error;

  stamp_t stamps_to_send[$];
  civil_t civil_due[$];
  int     tx_count = 0;
  int     rx_count = 0;
  int     errors = 0;
  int     hold_left = 0;
  bit     held = 1'b0;
  logic   hold_on = 1'b0;
  int     quiet = 0;
  civil_t got, want;

  epoch_to_civil_time dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday),
    .out_range_error  (out_range_error)
  );

  always #5 clk = ~clk;

  function automatic civil_t civil_of_epoch(stamp_t stamp);
    longint secs, days, sod, wd, z, era, doe, yoe, doy, mp, yy, mm, dd;
    civil_t c;
    secs = stamp;
    c = '0;
    if (secs < longint'(ectc_pkg::SPAN_LOW) || secs > longint'(ectc_pkg::SPAN_HIGH)) begin
      c.range_error = 1'b1;
      return c;
    end
    days = secs / SECS_DAY;
    sod  = secs % SECS_DAY;
    if (sod < 0) begin
      sod  += SECS_DAY;
      days -= 1;
    end
    wd = (days + 4) % 7;
    if (wd < 0) wd += 7;
    z   = days + DAYS_SHIFT;
    era = z / DAYS_ERA;
    doe = z - era * DAYS_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dd  = doy - (153 * mp + 2) / 5 + 1;
    mm  = (mp < 10) ? mp + 3 : mp - 9;
    yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
    c.year    = yy[11:0];
    c.month   = mm[3:0];
    c.mday    = dd[4:0];
    c.hour    = 5'(sod / 3600);
    c.minute  = 6'((sod % 3600) / 60);
    c.second  = 6'(sod % 60);
    c.weekday = wd[2:0];
    return c;
  endfunction

  // day number since 1970-01-01 of a civil date, years 1900 and later
  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_ERA + doe - DAYS_SHIFT;
  endfunction

  function automatic longint stamp_at(longint y, longint m, longint d, longint sod);
    return day_number(y, m, d) * SECS_DAY + sod;
  endfunction

  function automatic longint random_date_stamp();
    longint y, m, d, len;
    y   = $urandom_range(2399, 1900);
    m   = $urandom_range(12, 1);
    len = (m == 12) ? day_number(y + 1, 1, 1) - day_number(y, 12, 1)
                    : day_number(y, m + 1, 1) - day_number(y, m, 1);
    // favour month ends so leap days and 31st days turn up often
    d = ($urandom_range(3) == 0) ? len - $urandom_range(2) : $urandom_range(len, 1);
    return stamp_at(y, m, d, $urandom_range(86399));
  endfunction

  task automatic queue_stamp(longint v);
    stamps_to_send.push_back(stamp_t'(v));
  endtask

  task automatic fill_stamps();
    longint lo, hi, span, r, v;
    lo   = ectc_pkg::SPAN_LOW;
    hi   = ectc_pkg::SPAN_HIGH;
    span = hi - lo + 1;
    queue_stamp(0);
    queue_stamp(-1);
    queue_stamp(lo);
    queue_stamp(lo - 1);
    queue_stamp(hi);
    queue_stamp(hi + 1);
    queue_stamp((longint'(1) << (EW - 1)) - 1);
    queue_stamp(-(longint'(1) << (EW - 1)));
    queue_stamp(-SECS_DAY);
    queue_stamp(-SECS_DAY - 1);
    queue_stamp(SECS_DAY - 1);
    queue_stamp(SECS_DAY);
    queue_stamp(stamp_at(1900, 2, 28, 86399));
    queue_stamp(stamp_at(1900, 3, 1, 0));
    queue_stamp(stamp_at(1904, 2, 29, 12345));
    queue_stamp(stamp_at(2000, 2, 29, 0));
    queue_stamp(stamp_at(2000, 12, 31, 86399));
    queue_stamp(stamp_at(2001, 1, 1, 0));
    queue_stamp(stamp_at(2038, 1, 19, 11647));
    queue_stamp(stamp_at(2100, 2, 28, 43200));
    queue_stamp(stamp_at(2100, 3, 1, 0));
    queue_stamp(stamp_at(2396, 2, 29, 86399));
    queue_stamp(stamp_at(2399, 12, 31, 0));
    repeat (N_RANDOM) begin
      r = {$urandom, $urandom};
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v = random_date_stamp();
        6, 7: v = lo + ((r & 64'h7fff_ffff_ffff_ffff) % span);
        8: v = stamp_t'(r);
        default: begin
          case ($urandom_range(3))
            0: v = lo;
            1: v = hi + 1;
            2: v = 0;
            default: v = stamp_at($urandom_range(2399, 1900), $urandom_range(12, 1), 1, 0);
          endcase
          v = v + $urandom_range(20) - 10;
        end
      endcase
      queue_stamp(v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        civil_due.push_back(civil_of_epoch(in_epoch_seconds));
        tx_count++;
      end
      if (!in_valid || !in_stall) begin
        if (stamps_to_send.size() != 0 &&
            (hold_on || (tx_count >= STEADY_LO && tx_count < STEADY_HI) ||
             $urandom_range(99) >= GAP_PCT)) begin
          in_valid         <= 1'b1;
          in_epoch_seconds <= stamps_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_on   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_year, out_month, out_day_of_month, out_hour, out_minute,
                out_second, out_weekday, out_range_error};
        if (civil_due.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("unexpected result beat %0d: %p", rx_count, got);
        end else begin
          want = civil_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= SHOW_MAX) begin
              $display("mismatch at beat %0d", rx_count);
              $display("  expected %0d-%0d-%0d %0d:%0d:%0d wd %0d err %0d", want.year,
                       want.month, want.mday, want.hour, want.minute, want.second,
                       want.weekday, want.range_error);
              $display("  actual   %0d-%0d-%0d %0d:%0d:%0d wd %0d err %0d", got.year,
                       got.month, got.mday, got.hour, got.minute, got.second,
                       got.weekday, got.range_error);
            end
          end
        end
        rx_count++;
      end
      if (!held && rx_count >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_count >= STEADY_LO && rx_count < STEADY_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < GAP_PCT);
      end
      hold_on <= (hold_left > 0);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    fill_stamps();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (stamps_to_send.size() != 0 || in_valid || civil_due.size() != 0);
    repeat (DRAIN) @(negedge clk);
    if (errors == 0 && civil_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
